// ===== rtl/core/slcd_pkg.sv =====
// Shared types, constants and CRC-8 functions of the sync/length/CRC-8 deframer.
`default_nettype none
package slcd_pkg;

    localparam int NPROF = 4;

    // Frame layout constants.
    localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND = 8'h5A;
    localparam logic [15:0] MIN_LENGTH  = 16'd2;
    localparam logic [15:0] MAX_LENGTH  = 16'd16384;
    localparam int          IDX_W       = 14;
    localparam int          LEN_W       = 15;

    // CRC mode register codes.
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_CRC8  = 3'd1;
    localparam logic [2:0] MODE_ITU   = 3'd2;
    localparam logic [2:0] MODE_MAXIM = 3'd3;
    localparam logic [2:0] MODE_ROHC  = 3'd4;
    localparam logic [2:0] MODE_AUTO  = 3'd5;

    // Active profile code reported while auto mode has not locked yet.
    localparam logic [2:0] PROF_UNLOCKED = 3'd5;

    // Profile table, in lock priority order: plain crc8, ITU variant, maxim, rohc.
    localparam logic [7:0] PROF_POLY [NPROF] = '{8'h07, 8'h07, 8'h31, 8'h07};
    localparam logic [7:0] PROF_INIT [NPROF] = '{8'h00, 8'h00, 8'h00, 8'hFF};
    localparam logic [7:0] PROF_XOUT [NPROF] = '{8'h00, 8'h55, 8'h00, 8'h00};
    localparam logic       PROF_REFL [NPROF] = '{1'b0, 1'b0, 1'b1, 1'b1};

    // Register address decode: one 32-bit register at byte address 0.
    localparam int  ADDR_W   = 3;
    localparam logic REG_CRC_MODE = 1'b0;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CRC_FAIL = 2'd2,
        KIND_BAD_LEN  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_LEN0  = 3'd2,
        PH_LEN1  = 3'd3,
        PH_ID    = 3'd4,
        PH_DATA  = 3'd5,
        PH_CRC   = 3'd6
    } t_phase;

    typedef struct packed {
        logic       wr;
        logic [2:0] mode;
    } t_cfg;

    typedef struct packed {
        logic restart;
        logic feed;
    } t_crc_ctl;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        payload_byte;
        logic [7:0]        message_id;
        logic [IDX_W-1:0]  byte_index;
        logic [2:0]        active_profile;
        logic [31:0]       good_frames;
        logic [31:0]       crc_failures;
        logic [31:0]       length_errors;
        logic [31:0]       dropped_bytes;
    } t_result;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // One byte through the MSB-first shift register of profile p.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [1:0] p);
        logic [7:0] c;
        c = crc ^ (PROF_REFL[p] ? bit_rev8(b) : b);
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ PROF_POLY[p];
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] crc_final(input logic [7:0] crc, input logic [1:0] p);
        return (PROF_REFL[p] ? bit_rev8(crc) : crc) ^ PROF_XOUT[p];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sync_length_crc8_deframer.sv =====
// Top level of the sync/length/CRC-8 deframer: register port, parser, CRC lanes, result register.
//
//  Channel   Direction  Handshake                 Beat contents
//  input     in         i_in_valid / o_in_ready   i_data_byte
//  output    out        o_out_valid / i_out_ready kind, payload, id, index, profile, counters
//  config    in         APB psel/penable/pwrite   crc_mode at byte address 0
//
//  Each input beat is handled in the cycle it is accepted; its result, if any, appears in
//  the result register on the next cycle. One beat per cycle is sustained while the output is not stalled.
//  The CRC lanes and frame state update in that same cycle, so the rate is set by the
//  single-byte CRC-8 update and the phase logic.
//  Reset is synchronous: the parser returns to sync hunt and crc_mode to auto.
//  An input beat is taken whenever the result register is empty or is being emptied.
`default_nettype none
module sync_length_crc8_deframer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [slcd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_data_byte,
    // Output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_payload_byte,
    output logic [7:0]                        o_message_id,
    output logic [slcd_pkg::IDX_W-1:0]        o_byte_index,
    output logic [2:0]                        o_active_profile,
    output logic [31:0]                       o_good_frames,
    output logic [31:0]                       o_crc_failures,
    output logic [31:0]                       o_length_errors,
    output logic [31:0]                       o_dropped_bytes
);

    logic [2:0]          r_crc_mode;
    logic                r_out_valid, n_out_valid;
    slcd_pkg::t_result   r_res;
    slcd_pkg::t_cfg      cfg;
    slcd_pkg::t_crc_ctl  crc_ctl;
    slcd_pkg::t_result   res;
    logic                res_valid;
    logic                in_accept;
    logic                mode_wr;
    logic [7:0]          crc_final [slcd_pkg::NPROF];

    assign pready  = 1'b1;
    assign mode_wr = psel && penable && pwrite && (paddr[2] == slcd_pkg::REG_CRC_MODE);
    assign prdata  = (paddr[2] == slcd_pkg::REG_CRC_MODE) ? {29'd0, r_crc_mode} : 32'd0;

    assign cfg.wr   = mode_wr;
    assign cfg.mode = r_crc_mode;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mode <= slcd_pkg::MODE_AUTO;
        end else if (mode_wr) begin
            r_crc_mode <= pwdata[2:0];
        end
    end

    slcd_crc_bank u_crc_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_data_byte),
        .o_final (crc_final)
    );

    slcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_byte      (i_data_byte),
        .i_crc_final (crc_final),
        .o_crc_ctl   (crc_ctl),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = res_valid;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_res.kind;
    assign o_payload_byte   = r_res.payload_byte;
    assign o_message_id     = r_res.message_id;
    assign o_byte_index     = r_res.byte_index;
    assign o_active_profile = r_res.active_profile;
    assign o_good_frames    = r_res.good_frames;
    assign o_crc_failures   = r_res.crc_failures;
    assign o_length_errors  = r_res.length_errors;
    assign o_dropped_bytes  = r_res.dropped_bytes;

    // Only data beats carry a payload byte.
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != slcd_pkg::KIND_DATA) |-> o_payload_byte == 8'd0)
        else $error("payload byte set on a non-data result");

    // A rejected header reports no id and no index.
    a_bad_len_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == slcd_pkg::KIND_BAD_LEN)
        |-> (o_message_id == 8'd0) && (o_byte_index == '0))
        else $error("bad length result carries id or index");

    // A held result must block the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result register is full");

    a_profile_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_active_profile != 3'd6) && (o_active_profile != 3'd7))
        else $error("active profile out of range");

    // A good frame bumps the good-frame count by one against the parser's count before that frame.
    a_good_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && res_valid && (res.kind == slcd_pkg::KIND_GOOD)
        |=> o_good_frames == $past(u_parser.r_good) + 32'd1)
        else $error("good frame count did not advance");

endmodule
`default_nettype wire

// ===== rtl/core/slcd_crc_bank.sv =====
// Four CRC-8 lanes updated in parallel, one byte per cycle while fed, with their final values.
`default_nettype none
module slcd_crc_bank (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slcd_pkg::t_crc_ctl   i_ctl,
    input  wire logic [7:0]           i_byte,
    output logic [7:0]                o_final [slcd_pkg::NPROF]
);

    logic [7:0] r_crc [slcd_pkg::NPROF];
    logic [7:0] n_crc [slcd_pkg::NPROF];

    for (genvar p = 0; p < slcd_pkg::NPROF; p++) begin : g_lane
        always_comb begin
            if (i_ctl.restart) begin
                n_crc[p] = slcd_pkg::PROF_INIT[p];
            end else if (i_ctl.feed) begin
                n_crc[p] = slcd_pkg::crc_feed(r_crc[p], i_byte, 2'(p));
            end else begin
                n_crc[p] = r_crc[p];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_crc[p] <= slcd_pkg::PROF_INIT[p];
            end else begin
                r_crc[p] <= n_crc[p];
            end
        end

        assign o_final[p] = slcd_pkg::crc_final(r_crc[p], 2'(p));
    end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_parser.sv =====
// Frame parser: sync hunt, length check, id and data, CRC check, lock and counters.
`default_nettype none
module slcd_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slcd_pkg::t_cfg       i_cfg,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    input  wire logic [7:0]           i_crc_final [slcd_pkg::NPROF],
    output slcd_pkg::t_crc_ctl        o_crc_ctl,
    output logic                      o_res_valid,
    output slcd_pkg::t_result         o_res
);

    slcd_pkg::t_phase r_phase, n_phase;
    logic [7:0]                  r_len_lo, n_len_lo;
    logic [slcd_pkg::LEN_W-1:0]  r_frame_len, n_frame_len;
    logic [slcd_pkg::IDX_W-1:0]  r_data_count, n_data_count;
    logic [7:0]                  r_msg_id, n_msg_id;
    logic                        r_lock_valid, n_lock_valid;
    logic [1:0]                  r_lock_idx, n_lock_idx;
    logic [31:0]                 r_good, n_good;
    logic [31:0]                 r_crc_fail, n_crc_fail;
    logic [31:0]                 r_len_err, n_len_err;
    logic [31:0]                 r_dropped, n_dropped;

    logic [15:0]                 full_len;
    logic                        len_bad;
    logic [slcd_pkg::LEN_W-1:0]  count_plus;
    logic                        data_last;
    logic [2:0]                  mode_m1;
    logic                        crc_ok;
    logic                        any_match;
    logic [1:0]                  match_idx;

    assign full_len   = {i_byte, r_len_lo};
    assign len_bad    = (full_len < slcd_pkg::MIN_LENGTH) || (full_len > slcd_pkg::MAX_LENGTH);
    assign count_plus = slcd_pkg::LEN_W'(r_data_count) + slcd_pkg::LEN_W'(3);
    assign data_last  = count_plus >= r_frame_len;
    assign mode_m1    = i_cfg.mode - 3'd1;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                slcd_pkg::PH_HUNT0: begin
                    if (i_byte == slcd_pkg::SYNC_FIRST) n_phase = slcd_pkg::PH_HUNT1;
                end
                slcd_pkg::PH_HUNT1: begin
                    if (i_byte == slcd_pkg::SYNC_SECOND) begin
                        n_phase = slcd_pkg::PH_LEN0;
                    end else if (i_byte != slcd_pkg::SYNC_FIRST) begin
                        n_phase = slcd_pkg::PH_HUNT0;
                    end
                end
                slcd_pkg::PH_LEN0: n_phase = slcd_pkg::PH_LEN1;
                slcd_pkg::PH_LEN1: begin
                    n_phase = len_bad ? slcd_pkg::PH_HUNT0 : slcd_pkg::PH_ID;
                end
                slcd_pkg::PH_ID: begin
                    n_phase = (r_frame_len == slcd_pkg::LEN_W'(slcd_pkg::MIN_LENGTH))
                            ? slcd_pkg::PH_CRC : slcd_pkg::PH_DATA;
                end
                slcd_pkg::PH_DATA: begin
                    if (data_last) n_phase = slcd_pkg::PH_CRC;
                end
                default: n_phase = slcd_pkg::PH_HUNT0;
            endcase
        end
    end

    // First matching profile in table order, for the auto-mode lock.
    always_comb begin
        any_match = 1'b0;
        match_idx = 2'd0;
        for (int p = slcd_pkg::NPROF - 1; p >= 0; p--) begin
            if (i_crc_final[p] == i_byte) begin
                any_match = 1'b1;
                match_idx = 2'(p);
            end
        end
    end

    // Datapath, counters and result.
    always_comb begin
        n_len_lo     = r_len_lo;
        n_frame_len  = r_frame_len;
        n_data_count = r_data_count;
        n_msg_id     = r_msg_id;
        n_lock_valid = r_lock_valid;
        n_lock_idx   = r_lock_idx;
        n_good       = r_good;
        n_crc_fail   = r_crc_fail;
        n_len_err    = r_len_err;
        n_dropped    = r_dropped;
        o_crc_ctl    = '0;
        o_res_valid  = 1'b0;
        crc_ok       = 1'b0;

        o_res.kind         = slcd_pkg::KIND_DATA;
        o_res.payload_byte = 8'd0;
        o_res.message_id   = r_msg_id;
        o_res.byte_index   = r_data_count;

        if (i_cfg.mode == slcd_pkg::MODE_NONE) begin
            crc_ok = 1'b1;
        end else if (i_cfg.mode inside {[slcd_pkg::MODE_CRC8:slcd_pkg::MODE_ROHC]}) begin
            crc_ok = i_crc_final[mode_m1[1:0]] == i_byte;
        end else if (i_cfg.mode == slcd_pkg::MODE_AUTO) begin
            crc_ok = r_lock_valid ? (i_crc_final[r_lock_idx] == i_byte) : any_match;
        end

        if (i_accept) begin
            case (r_phase)
                slcd_pkg::PH_HUNT0: begin
                    if (i_byte != slcd_pkg::SYNC_FIRST) n_dropped = r_dropped + 32'd1;
                end
                slcd_pkg::PH_HUNT1: begin
                    if (i_byte == slcd_pkg::SYNC_FIRST) begin
                        n_dropped = r_dropped + 32'd1;
                    end else if (i_byte != slcd_pkg::SYNC_SECOND) begin
                        n_dropped = r_dropped + 32'd2;
                    end
                end
                slcd_pkg::PH_LEN0: n_len_lo = i_byte;
                slcd_pkg::PH_LEN1: begin
                    if (len_bad) begin
                        n_len_err          = r_len_err + 32'd1;
                        o_res_valid        = 1'b1;
                        o_res.kind         = slcd_pkg::KIND_BAD_LEN;
                        o_res.message_id   = 8'd0;
                        o_res.byte_index   = '0;
                    end else begin
                        n_frame_len       = full_len[slcd_pkg::LEN_W-1:0];
                        n_data_count      = '0;
                        o_crc_ctl.restart = 1'b1;
                    end
                end
                slcd_pkg::PH_ID: begin
                    n_msg_id       = i_byte;
                    o_crc_ctl.feed = 1'b1;
                end
                slcd_pkg::PH_DATA: begin
                    o_crc_ctl.feed     = 1'b1;
                    n_data_count       = r_data_count + slcd_pkg::IDX_W'(1);
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                end
                slcd_pkg::PH_CRC: begin
                    o_res_valid = 1'b1;
                    if (crc_ok) begin
                        n_good     = r_good + 32'd1;
                        o_res.kind = slcd_pkg::KIND_GOOD;
                        if (i_cfg.mode == slcd_pkg::MODE_AUTO && !r_lock_valid) begin
                            n_lock_valid = 1'b1;
                            n_lock_idx   = match_idx;
                        end
                    end else begin
                        n_crc_fail = r_crc_fail + 32'd1;
                        o_res.kind = slcd_pkg::KIND_CRC_FAIL;
                    end
                end
                default: ;
            endcase
        end

        if (i_cfg.wr) n_lock_valid = 1'b0;

        // The report carries the profile and counters as they stand after this byte.
        if (i_cfg.mode inside {[slcd_pkg::MODE_CRC8:slcd_pkg::MODE_ROHC]}) begin
            o_res.active_profile = i_cfg.mode;
        end else if (i_cfg.mode == slcd_pkg::MODE_AUTO) begin
            o_res.active_profile = n_lock_valid ? {1'b0, n_lock_idx} + 3'd1
                                                : slcd_pkg::PROF_UNLOCKED;
        end else begin
            o_res.active_profile = slcd_pkg::MODE_NONE;
        end
        o_res.good_frames   = n_good;
        o_res.crc_failures  = n_crc_fail;
        o_res.length_errors = n_len_err;
        o_res.dropped_bytes = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= slcd_pkg::PH_HUNT0;
            r_len_lo     <= '0;
            r_frame_len  <= '0;
            r_data_count <= '0;
            r_msg_id     <= '0;
            r_lock_valid <= 1'b0;
            r_lock_idx   <= '0;
            r_good       <= '0;
            r_crc_fail   <= '0;
            r_len_err    <= '0;
            r_dropped    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_len_lo     <= n_len_lo;
            r_frame_len  <= n_frame_len;
            r_data_count <= n_data_count;
            r_msg_id     <= n_msg_id;
            r_lock_valid <= n_lock_valid;
            r_lock_idx   <= n_lock_idx;
            r_good       <= n_good;
            r_crc_fail   <= n_crc_fail;
            r_len_err    <= n_len_err;
            r_dropped    <= n_dropped;
        end
    end

endmodule
`default_nettype wire
